>>> hdl/siph_pkg.sv
package siph_pkg;

    localparam int unsigned WORD_W = 64;

    // Initialization constants
    localparam logic [WORD_W-1:0] IV_ZERO  = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV_ONE   = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV_TWO   = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV_THREE = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

    // Configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Operation codes; the fourth code is ignored
    typedef enum logic [1:0] {
        OP_ABSORB        = 2'd0,
        OP_ABSORB_FINISH = 2'd1,
        OP_FINISH        = 2'd2,
        OP_UNUSED        = 2'd3
    } siph_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } siph_lanes_t;

endpackage

>>> hdl/siphash_2_4_word_stream.sv
// Keyed SipHash-2-4 over whole 64-bit words, one SipRound per clock.
// An absorb XORs the word into v3, runs two SipRounds and then XORs the word
// into v0; a finish runs four SipRounds and then loads the output register.
// The single shared round unit serves every phase, so no new word is
// accepted until the previous operation, including the tag hand-off, is done.
// Reset (rst_n low, async): key registers clear to zero, no message open.
module siphash_2_4_word_stream (
    input  logic        clk,
    input  logic        rst_n,
    // input transaction
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [63:0] message_word,
    // result transaction
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import siph_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;       // round counter within a phase
    logic              open_reg, open_next;     // message open
    logic              fin_reg, fin_next;       // finish after absorbing
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] key_low_reg, key_high_reg;
    siph_lanes_t       lanes_reg, lanes_next;
    siph_lanes_t       start_lanes;
    siph_lanes_t       round_out;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] hash_reg, hash_next;
    logic              in_fire;
    logic              out_free;

    // The shared round unit always works on the stored lanes
    siph_round u_round (
        .lanes_in  (lanes_reg),
        .lanes_out (round_out)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // Lanes at the start of a transaction: fresh from the key if no message open
    always_comb
    begin
        if (open_reg)
        begin
            start_lanes = lanes_reg;
        end
        else
        begin
            start_lanes.v0 = IV_ZERO  ^ key_low_reg;
            start_lanes.v1 = IV_ONE   ^ key_high_reg;
            start_lanes.v2 = IV_TWO   ^ key_low_reg;
            start_lanes.v3 = IV_THREE ^ key_high_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        open_next      = open_reg;
        fin_next       = fin_reg;
        word_next      = word_reg;
        lanes_next     = lanes_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next = 2'd0;
                    if (op == OP_ABSORB || op == OP_ABSORB_FINISH)
                    begin
                        lanes_next    = start_lanes;
                        lanes_next.v3 = start_lanes.v3 ^ message_word;
                        word_next     = message_word;
                        fin_next      = (op == OP_ABSORB_FINISH);
                        open_next     = 1'b1;
                        state_next    = ST_ABSORB;
                    end
                    else if (op == OP_FINISH)
                    begin
                        lanes_next    = start_lanes;
                        lanes_next.v2 = start_lanes.v2 ^ FINAL_MARK;
                        open_next     = 1'b0;
                        state_next    = ST_FINISH;
                    end
                end
            end
            ST_ABSORB:
            begin
                lanes_next = round_out;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    lanes_next.v0 = round_out.v0 ^ word_reg;
                    cnt_next      = 2'd0;
                    if (fin_reg)
                    begin
                        lanes_next.v2 = round_out.v2 ^ FINAL_MARK;
                        open_next     = 1'b0;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                lanes_next = round_out;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // wait here until the previous tag has been taken
                if (out_free)
                begin
                    hash_next      = lanes_reg.v0 ^ lanes_reg.v1 ^ lanes_reg.v2 ^ lanes_reg.v3;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            open_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_LOW)
                begin
                    key_low_reg <= cfg_data;
                end
                else if (cfg_index == CFG_KEY_HIGH)
                begin
                    key_high_reg <= cfg_data;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        lanes_reg <= lanes_next;
        word_reg  <= word_next;
        hash_reg  <= hash_next;
    end

endmodule

>>> hdl/siph_round.sv
module siph_round (
    input  siph_pkg::siph_lanes_t lanes_in,
    output siph_pkg::siph_lanes_t lanes_out
);
    import siph_pkg::*;

    logic [WORD_W-1:0] a0;
    logic [WORD_W-1:0] a0r;
    logic [WORD_W-1:0] b1;
    logic [WORD_W-1:0] a2;
    logic [WORD_W-1:0] b3;
    logic [WORD_W-1:0] c0;
    logic [WORD_W-1:0] c1;
    logic [WORD_W-1:0] c2;
    logic [WORD_W-1:0] c3;

    // One SipRound: add-rotate-xor network over the four lanes
    always_comb
    begin
        a0  = lanes_in.v0 + lanes_in.v1;
        b1  = {lanes_in.v1[50:0], lanes_in.v1[63:51]} ^ a0;
        a0r = {a0[31:0], a0[63:32]};
        a2  = lanes_in.v2 + lanes_in.v3;
        b3  = {lanes_in.v3[47:0], lanes_in.v3[63:48]} ^ a2;
        c0  = a0r + b3;
        c3  = {b3[42:0], b3[63:43]} ^ c0;
        c2  = a2 + b1;
        c1  = {b1[46:0], b1[63:47]} ^ c2;
        lanes_out.v0 = c0;
        lanes_out.v1 = c1;
        lanes_out.v2 = {c2[31:0], c2[63:32]};
        lanes_out.v3 = c3;
    end

endmodule

>>> hdl/siph_check.sv
module siph_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] hash_value
);
    import siph_pkg::*;

    logic in_fire;
    assign in_fire = in_valid && !in_stall;

    // held tag stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("tag dropped or changed while stalled");

    // a real operation occupies the round unit next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op == OP_ABSORB || op == OP_ABSORB_FINISH || op == OP_FINISH)
        |=> in_stall)
        else $error("input not stalled after operation");

    // unused code is dropped without work
    a_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == OP_UNUSED |=> !in_stall)
        else $error("unused op code started work");

    // a tag only appears after the block was busy
    a_tag_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("tag without preceding work");

    // plain absorb produces no tag during its rounds
    a_absorb_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == OP_ABSORB |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("tag after plain absorb");

endmodule

bind siphash_2_4_word_stream siph_check u_siph_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);
